// ===== design/sse_pkg.sv =====
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types, character codes and helpers for the string escape encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sse_pkg;

	// widths of the fields and the longest run of result words per item
	localparam int unsigned ByteW   = 8;
	localparam int unsigned CapW    = 16;
	localparam int unsigned RunMax  = 5;
	localparam int unsigned RunCntW = 3;

	// capacity after reset
	localparam logic [CapW-1:0] CapReset = 16'd1024;

	// character codes
	localparam logic [ByteW-1:0] ChNul    = 8'h00;
	localparam logic [ByteW-1:0] ChTab    = 8'h09;
	localparam logic [ByteW-1:0] ChLf     = 8'h0A;
	localparam logic [ByteW-1:0] ChCr     = 8'h0D;
	localparam logic [ByteW-1:0] ChQuote  = 8'h22;
	localparam logic [ByteW-1:0] ChBslash = 8'h5C;
	localparam logic [ByteW-1:0] ChLetR   = 8'h72;
	localparam logic [ByteW-1:0] ChLetN   = 8'h6E;
	localparam logic [ByteW-1:0] ChLetT   = 8'h74;
	localparam logic [ByteW-1:0] ChLetX   = 8'h78;
	localparam logic [ByteW-1:0] ChSpace  = 8'h20;
	localparam logic [ByteW-1:0] ChDel    = 8'h7F;
	localparam logic [ByteW-1:0] ChZero   = 8'h30;
	localparam logic [ByteW-1:0] ChHexOfs = 8'h37;  // 'A' - 10

	// one item's result words, waiting to be sent
	typedef struct packed {
		logic [RunMax-1:0][ByteW-1:0] bytes;
		logic [RunCntW-1:0]           cnt;
		logic                         eos;
	} run_t;

	// upper-case hex digit of a nibble
	function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] nib);
		logic [ByteW-1:0] ext;
		ext = {4'd0, nib};
		return (nib < 4'd10) ? (ChZero + ext) : (ChHexOfs + ext);
	endfunction

endpackage

`default_nettype wire

// ===== design/sse_in_if.sv =====
// ----------------------------------------------------------------------------
// sse_in_if
// Input channel: one source string byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

// ===== design/sse_out_if.sv =====
// ----------------------------------------------------------------------------
// sse_out_if
// Output channel: one escaped byte or terminator per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       is_terminator;

	modport source (output valid, output out_byte, output last_of_run,
		output is_terminator, input ready);
	modport sink (input valid, input out_byte, input last_of_run,
		input is_terminator, output ready);
endinterface

`default_nettype wire

// ===== design/sse_encode.sv =====
// ----------------------------------------------------------------------------
// sse_encode
// Escapes one source byte, checks it against the buffer capacity and keeps
// the per-string byte count, stop flag and capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_encode
	import sse_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CapW-1:0]  cfg_wr_data,
	input  wire logic             accept,
	input  wire logic [ByteW-1:0] in_byte,
	input  wire logic             end_of_string,
	output run_t                  run
);

	logic [CapW-1:0] capacity_q;
	logic [CapW-1:0] written_q;
	logic            stopped_q;

	logic [CapW-1:0] limit;
	logic [CapW:0]   wr_ext;
	logic [CapW:0]   lim_ext;
	logic            is_two;
	logic            is_hex;
	logic [ByteW-1:0] letter;
	logic            fits;
	logic [RunCntW-1:0] n_body;
	logic            stop_now;

	// limit leaves one place for the terminator, saturating at zero
	assign limit   = (capacity_q == '0) ? '0 : capacity_q - CapW'(1);
	assign wr_ext  = {1'b0, written_q};
	assign lim_ext = {1'b0, limit};

	// classify the byte
	always_comb begin
		is_two = 1'b1;
		letter = in_byte;
		case (in_byte)
			ChQuote:  letter = ChQuote;
			ChBslash: letter = ChBslash;
			ChCr:     letter = ChLetR;
			ChLf:     letter = ChLetN;
			ChTab:    letter = ChLetT;
			default:  is_two = 1'b0;
		endcase
	end

	assign is_hex = !is_two && ((in_byte < ChSpace) || (in_byte > ChDel));

	// fit check and result words
	always_comb begin
		run       = '0;
		n_body    = '0;
		fits      = 1'b0;
		stop_now  = 1'b0;
		if (!stopped_q) begin
			if (in_byte == ChNul) begin
				stop_now = 1'b1;
			end else if (is_two) begin
				fits = (wr_ext + (CapW+1)'(2)) < lim_ext;
				if (fits) begin
					run.bytes[0] = ChBslash;
					run.bytes[1] = letter;
					n_body       = RunCntW'(2);
				end
			end else if (is_hex) begin
				fits = (wr_ext + (CapW+1)'(4)) < lim_ext;
				if (fits) begin
					run.bytes[0] = ChBslash;
					run.bytes[1] = ChLetX;
					run.bytes[2] = hex_digit(in_byte[7:4]);
					run.bytes[3] = hex_digit(in_byte[3:0]);
					n_body       = RunCntW'(4);
				end
			end else begin
				fits = wr_ext < lim_ext;
				if (fits) begin
					run.bytes[0] = in_byte;
					n_body       = RunCntW'(1);
				end
			end
			if (in_byte != ChNul && !fits) begin
				stop_now = 1'b1;
			end
		end
		// terminator sits right after the body; its byte is already zero
		run.cnt = n_body + RunCntW'(end_of_string);
		run.eos = end_of_string;
	end

	// string state and capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CapReset;
			written_q  <= '0;
			stopped_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (accept) begin
				if (end_of_string) begin
					written_q <= '0;
					stopped_q <= 1'b0;
				end else begin
					written_q <= written_q + CapW'(n_body);
					if (stop_now) begin
						stopped_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/sse_emit.sv =====
// ----------------------------------------------------------------------------
// sse_emit
// Holds one item's run of result words and sends them one per cycle through
// the output register while the output channel is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_emit
	import sse_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  wire run_t  run,
	output logic       load_ready,
	sse_out_if.source  out_ch
);

	run_t               run_s1;
	logic [RunCntW-1:0] pos_q;
	logic               busy_q;

	logic               out_valid_q;
	logic [ByteW-1:0]   out_byte_q;
	logic               out_last_q;
	logic               out_term_q;

	logic               out_adv;
	logic               at_last;
	logic               send;

	assign out_adv    = !out_valid_q || out_ch.ready;
	assign at_last    = (pos_q == run_s1.cnt - RunCntW'(1));
	assign send       = busy_q && out_adv;
	assign load_ready = !busy_q || (out_adv && at_last);

	// run buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (send) begin
				pos_q <= pos_q + RunCntW'(1);
				if (at_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_s1 <= run;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (send) begin
			out_byte_q <= run_s1.bytes[pos_q];
			out_last_q <= at_last;
			out_term_q <= at_last && run_s1.eos;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_byte      = out_byte_q;
	assign out_ch.last_of_run   = out_last_q;
	assign out_ch.is_terminator = out_term_q;

endmodule

`default_nettype wire

// ===== design/string_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// string_escape_encoder
// Escapes a C string byte stream into quoted/hex form with a capacity limit
// and a closing zero terminator.
// ----------------------------------------------------------------------------
// channel   dir  handshake     payload
// in_ch     in   valid/ready   in_byte[7:0], end_of_string
// out_ch    out  valid/ready   out_byte[7:0], last_of_run, is_terminator
// cfg       in   cfg_wr_en     cfg_wr_data[15:0] (out_capacity)
//
// a word is taken every cycle while each produces at most one output byte and
// the output is not stalled; an escape or terminator holds the input while
// the single output register sends its extra bytes, one byte per cycle while
// the output is ready. words that produce nothing load nothing into the run buffer.
// the first output byte passes through the run buffer and then the output register.
// reset clears the string state and sets the capacity to 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module string_escape_encoder
	import sse_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_wr_en,
	input  wire logic [CapW-1:0] cfg_wr_data,
	sse_in_if.sink               in_ch,
	sse_out_if.source            out_ch
);

	run_t run;
	logic load_ready;
	logic accept;
	logic load;

	// a word is taken whenever the run buffer can take its results
	assign in_ch.ready = load_ready;
	assign accept      = in_ch.valid && load_ready;
	assign load        = accept && (run.cnt != '0);

	sse_encode u_encode (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.accept        (accept),
		.in_byte       (in_ch.in_byte),
		.end_of_string (in_ch.end_of_string),
		.run           (run)
	);

	sse_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.run        (run),
		.load_ready (load_ready),
		.out_ch     (out_ch)
	);

endmodule

`default_nettype wire
